FILE: hdl/rlmn_pkg.sv
package rlmn_pkg;

	localparam int CORDIC_ITERATIONS = 28;

	// cordic datapath widths: 32 fraction bits plus headroom
	localparam int CW = 36;
	localparam int ZW = 34;
	localparam int RW = 61;   // radicand, up to 2^60
	localparam int NW = 31;   // root, up to 2^30

	localparam logic signed [CW-1:0] CORDIC_START = 36'sd2608131496;
	localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

	// register indexes
	localparam logic REG_REF_RA  = 1'b0;
	localparam logic REG_REF_DEC = 1'b1;

	typedef struct packed {
		logic [31:0]        ra;
		logic signed [31:0] dec;
	} item_t;

	typedef struct packed {
		logic signed [31:0] l_cosine;
		logic signed [31:0] m_cosine;
		logic [30:0]        n_cosine;
		logic               n_clamped;
	} result_t;

	// what rides alongside the root pipeline
	typedef struct packed {
		logic signed [31:0] l;
		logic signed [31:0] m;
		logic               clamped;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_turns(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd536870912;
			1: r = 34'sd316933406;
			2: r = 34'sd167458907;
			3: r = 34'sd85004756;
			4: r = 34'sd42667331;
			5: r = 34'sd21354465;
			6: r = 34'sd10679838;
			7: r = 34'sd5340245;
			8: r = 34'sd2670163;
			9: r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			24: r = 34'sd41;
			25: r = 34'sd20;
			26: r = 34'sd10;
			27: r = 34'sd5;
			28: r = 34'sd3;
			29: r = 34'sd1;
			30: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_q30(input logic signed [63:0] v);
		logic signed [63:0] r;
		if (v > ONE_Q30)
			r = ONE_Q30;
		else if (v < -ONE_Q30)
			r = -ONE_Q30;
		else
			r = v;
		return r[31:0];
	endfunction

	// floor((v + 2^29) / 2^30)
	function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
		return (v + 64'sd536870912) >>> 30;
	endfunction

endpackage

FILE: hdl/rlmn_cordic.sv
module rlmn_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [31:0]        angle,
	output logic               out_valid,
	output logic signed [31:0] cos_out,
	output logic signed [31:0] sin_out
);

	localparam int N = rlmn_pkg::CORDIC_ITERATIONS;

	logic signed [rlmn_pkg::CW-1:0] x_s [0:N];
	logic signed [rlmn_pkg::CW-1:0] y_s [0:N];
	logic signed [rlmn_pkg::ZW-1:0] z_s [0:N];
	logic                           flip_s [0:N];
	logic                           v_s [0:N];

	logic [31:0] shifted;
	logic        flip;
	logic [31:0] folded;

	// fold into [-quarter, +quarter] by a half turn
	assign shifted = angle + 32'h4000_0000;
	assign flip    = shifted[31];
	assign folded  = flip ? (angle ^ 32'h8000_0000) : angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= rlmn_pkg::CORDIC_START;
		y_s[0]    <= '0;
		z_s[0]    <= {{(rlmn_pkg::ZW-32){folded[31]}}, folded};
		flip_s[0] <= flip;
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][rlmn_pkg::ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - rlmn_pkg::atan_turns(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + rlmn_pkg::atan_turns(i);
			end
		end
	end

	logic signed [rlmn_pkg::CW-1:0] xf;
	logic signed [rlmn_pkg::CW-1:0] yf;
	logic signed [rlmn_pkg::CW-1:0] xr;
	logic signed [rlmn_pkg::CW-1:0] yr;

	assign xf = flip_s[N] ? -x_s[N] : x_s[N];
	assign yf = flip_s[N] ? -y_s[N] : y_s[N];
	assign xr = (xf + 36'sd2) >>> 2;
	assign yr = (yf + 36'sd2) >>> 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		cos_out <= rlmn_pkg::clamp_q30(64'(xr));
		sin_out <= rlmn_pkg::clamp_q30(64'(yr));
	end

endmodule

FILE: hdl/rlmn_sqrt.sv
module rlmn_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [rlmn_pkg::RW-1:0] rad,
	input  rlmn_pkg::side_t         side_in,
	output logic                    out_valid,
	output logic [rlmn_pkg::NW-1:0] root,
	output rlmn_pkg::side_t         side_out
);

	localparam int NW = rlmn_pkg::NW;

	logic [62:0]             rem_s  [0:NW-1];
	logic [NW-1:0]           root_s [0:NW-1];
	rlmn_pkg::side_t         side_s [0:NW-1];
	logic                    v_s    [0:NW-1];

	// one root bit per stage, most significant first
	for (genvar j = 0; j < NW; j++) begin : g_bit
		localparam int K = NW - 1 - j;
		logic [62:0]     rem_p;
		logic [NW-1:0]   root_p;
		rlmn_pkg::side_t side_p;
		logic            v_p;
		logic [62:0]     trial;

		if (j == 0) begin : g_first
			assign rem_p  = {{(63-rlmn_pkg::RW){1'b0}}, rad};
			assign root_p = '0;
			assign side_p = side_in;
			assign v_p    = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[j-1];
			assign root_p = root_s[j-1];
			assign side_p = side_s[j-1];
			assign v_p    = v_s[j-1];
		end

		assign trial = ({{(63-NW){1'b0}}, root_p} << (K + 1)) + (63'd1 << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			side_s[j] <= side_p;
			if (rem_p >= trial) begin
				rem_s[j]  <= rem_p - trial;
				root_s[j] <= root_p | (NW'(1) << K);
			end else begin
				rem_s[j]  <= rem_p;
				root_s[j] <= root_p;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign root      = root_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

FILE: hdl/radec_to_lmn_direction_cosines.sv
// channel   | signals                         | transfer when
// ----------+---------------------------------+-------------------------
// item in   | start, busy, item (ra, dec)     | start high, busy low
// result    | done, result (l, m, n, clamp)   | every cycle done is high
// config    | cfg_we, cfg_index, cfg_wdata    | cfg_we high
//
// fully pipelined: one item per cycle, busy is always low
// from start to done an item runs through the cordic rotation chain and the
// 31-stage digit-by-digit root
// reset clears the valid bits and both reference registers
// results cannot be held off; each shows for one cycle with done
module radec_to_lmn_direction_cosines (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rlmn_pkg::item_t   item,
	output logic              done,
	output rlmn_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_wdata
);

	logic [31:0] ref_ra_q;
	logic [31:0] ref_dec_q;

	// reference registers, to be written only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_ra_q  <= '0;
			ref_dec_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlmn_pkg::REG_REF_RA:  ref_ra_q  <= cfg_wdata;
				rlmn_pkg::REG_REF_DEC: ref_dec_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic        take;
	logic [31:0] dra;

	assign take = start && !busy;
	assign dra  = item.ra - ref_ra_q;   // wraps modulo a full turn

	// three cordic lanes in lockstep: dec, ref_dec, ra - ref_ra
	logic               vd, vr, va;
	logic signed [31:0] cd, sd, crd, srd, cdr, sdr;

	rlmn_cordic u_cordic_dec (
		.clk(clk), .arst_n(arst_n), .in_valid(take), .angle(item.dec),
		.out_valid(vd), .cos_out(cd), .sin_out(sd)
	);

	rlmn_cordic u_cordic_ref (
		.clk(clk), .arst_n(arst_n), .in_valid(take), .angle(ref_dec_q),
		.out_valid(vr), .cos_out(crd), .sin_out(srd)
	);

	rlmn_cordic u_cordic_dra (
		.clk(clk), .arst_n(arst_n), .in_valid(take), .angle(dra),
		.out_valid(va), .cos_out(cdr), .sin_out(sdr)
	);

	// s1: first products
	logic               v_s1;
	logic signed [63:0] lp_s1, tp_s1, pp_s1;
	logic signed [31:0] cdr_s1;

	// s2: round l and t
	logic               v_s2;
	logic signed [31:0] l_s2, t_s2, cdr_s2;
	logic signed [63:0] pp_s2;

	// s3: t * cos(dra)
	logic               v_s3;
	logic signed [31:0] l_s3;
	logic signed [63:0] pp_s3, q_s3;

	// s4: round m
	logic               v_s4;
	logic signed [31:0] l_s4, m_s4;

	// s5: squares
	logic               v_s5;
	logic signed [31:0] l_s5, m_s5;
	logic signed [63:0] ll_s5, mm_s5;

	// s6: radicand and clamp flag
	logic               v_s6;
	logic signed [31:0] l_s6, m_s6;
	logic signed [63:0] rad_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= vd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		lp_s1  <= 64'(cd) * 64'(sdr);
		tp_s1  <= 64'(cd) * 64'(srd);
		pp_s1  <= 64'(sd) * 64'(crd);
		cdr_s1 <= cdr;

		l_s2   <= rlmn_pkg::clamp_q30(rlmn_pkg::round_q30(lp_s1));
		t_s2   <= rlmn_pkg::clamp_q30(rlmn_pkg::round_q30(tp_s1));
		pp_s2  <= pp_s1;
		cdr_s2 <= cdr_s1;

		q_s3   <= 64'(t_s2) * 64'(cdr_s2);
		pp_s3  <= pp_s2;
		l_s3   <= l_s2;

		m_s4   <= rlmn_pkg::clamp_q30(rlmn_pkg::round_q30(pp_s3 - q_s3));
		l_s4   <= l_s3;

		ll_s5  <= 64'(l_s4) * 64'(l_s4);
		mm_s5  <= 64'(m_s4) * 64'(m_s4);
		l_s5   <= l_s4;
		m_s5   <= m_s4;

		rad_s6 <= (64'sd1 <<< 60) - ll_s5 - mm_s5;
		l_s6   <= l_s5;
		m_s6   <= m_s5;
	end

	// negative radicand feeds zero to the root and raises the flag
	logic                    neg;
	logic [rlmn_pkg::RW-1:0] rad_in;
	rlmn_pkg::side_t         side_in, side_out;
	logic                    sq_valid;
	logic [rlmn_pkg::NW-1:0] root;

	assign neg             = rad_s6[63];
	assign rad_in          = neg ? '0 : rad_s6[rlmn_pkg::RW-1:0];
	assign side_in.l       = l_s6;
	assign side_in.m       = m_s6;
	assign side_in.clamped = neg;

	rlmn_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s6), .rad(rad_in),
		.side_in(side_in), .out_valid(sq_valid), .root(root),
		.side_out(side_out)
	);

	// output register, one cycle per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		result.l_cosine  <= side_out.l;
		result.m_cosine  <= side_out.m;
		result.n_cosine  <= root;
		result.n_clamped <= side_out.clamped;
	end

`ifndef SYNTHESIS
	// the three cordic lanes must stay aligned
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(vd == vr) && (vd == va))
		else $error("cordic lanes out of step");

	// a clamped result carries a zero n
	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.n_clamped) |-> (result.n_cosine == '0))
		else $error("clamped result with nonzero n");

	// l stays within one
	a_l_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.l_cosine <= 32'sd1073741824) &&
			(result.l_cosine >= -32'sd1073741824)))
		else $error("l out of range");

	// done follows a result leaving the root pipeline
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid |=> done)
		else $error("result lost at output register");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY  = rlmn_pkg::CORDIC_ITERATIONS + 40;
	localparam int WATCHDOG = 4000;

	// one result per accepted item, so the watchdog cannot fire on a sound pipeline
	localparam logic signed [63:0] Q30 = 64'sd1073741824;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	rlmn_pkg::item_t   item = '0;
	logic              done;
	rlmn_pkg::result_t result;
	logic              cfg_we = 1'b0;
	logic              cfg_index = rlmn_pkg::REG_REF_RA;
	logic [31:0]       cfg_wdata = '0;

	// predictor copy of the reference registers
	logic [31:0] phase_ra = '0;
	logic [31:0] phase_dec = '0;

	rlmn_pkg::result_t cosines_due[$];
	int                mismatches = 0;
	int                idle_cycles = 0;

	radec_to_lmn_direction_cosines uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// arctangent table in units of 2^-32 turn
	function automatic longint atan_step(input int i);
		longint tab [32];
		tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return tab[i];
	endfunction

	function automatic longint sat_unit(input longint v);
		if (v > Q30)
			return Q30;
		if (v < -Q30)
			return -Q30;
		return v;
	endfunction

	// rotation cordic, folded into the right half plane first
	task automatic angle_sincos(input logic [31:0] a, output longint c, output longint s);
		logic   fold;
		longint x, y, z, dx, dy;
		fold = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
		if (fold)
			a = a ^ 32'h8000_0000;
		z = longint'($signed(a));
		x = 64'sd2608131496;
		y = 0;
		for (int i = 0; i < rlmn_pkg::CORDIC_ITERATIONS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_step(i);
			end else begin
				x = x + dx; y = y - dy; z = z + atan_step(i);
			end
		end
		if (fold) begin
			x = -x; y = -y;
		end
		c = sat_unit((x + 2) >>> 2);
		s = sat_unit((y + 2) >>> 2);
	endtask

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	task automatic predict_cosines(input rlmn_pkg::item_t it, output rlmn_pkg::result_t r);
		longint cd, sd, crd, srd, cdr, sdr, l, m, t, rad;
		angle_sincos(it.dec, cd, sd);
		angle_sincos(phase_dec, crd, srd);
		angle_sincos(it.ra - phase_ra, cdr, sdr);
		l = sat_unit((cd * sdr + 64'sd536870912) >>> 30);
		t = sat_unit((cd * srd + 64'sd536870912) >>> 30);
		m = sat_unit((sd * crd - t * cdr + 64'sd536870912) >>> 30);
		rad = (64'sd1 <<< 60) - l * l - m * m;
		r.l_cosine = l[31:0];
		r.m_cosine = m[31:0];
		if (rad < 0) begin
			r.n_cosine = '0;
			r.n_clamped = 1'b1;
		end else begin
			r.n_cosine = 31'(int_root(rad));
			r.n_clamped = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// checker: results arrive with done high, one cycle each
	always @(posedge clk) begin
		rlmn_pkg::result_t want;
		if (start && !busy || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && done) begin
			if (cosines_due.size() == 0) begin
				report_mismatch("unexpected result", result.l_cosine, 32'h0);
			end else begin
				want = cosines_due.pop_front();
				if (result.l_cosine !== want.l_cosine)
					report_mismatch("l_cosine", result.l_cosine, want.l_cosine);
				if (result.m_cosine !== want.m_cosine)
					report_mismatch("m_cosine", result.m_cosine, want.m_cosine);
				if (result.n_cosine !== want.n_cosine)
					report_mismatch("n_cosine", result.n_cosine, want.n_cosine);
				if (result.n_clamped !== want.n_clamped)
					report_mismatch("n_clamped", result.n_clamped, want.n_clamped);
			end
		end
	end

	// watchdog on cycles with no transfer either way
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	int burst_left = 0;

	// send one direction; bursts with random gaps in between
	task automatic send_direction(input logic [31:0] ra, input logic [31:0] dec);
		rlmn_pkg::result_t r;
		int                gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start <= 1'b1;
		item <= '{ra: ra, dec: dec};
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_cosines('{ra: ra, dec: dec}, r);
		cosines_due.push_back(r);
		@(negedge clk);
	endtask

	// hold off the sender until the pipeline has drained
	task automatic drain_pipeline();
		start <= 1'b0;
		burst_left = 0;
		while (cosines_due.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reference(input logic idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rlmn_pkg::REG_REF_RA)
			phase_ra = value;
		else
			phase_dec = value;
		@(negedge clk);
	endtask

	// a declination with random bits, mostly within the legal range
	function automatic logic [31:0] pick_dec();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
	endfunction

	task automatic test_extremes();
		logic [31:0] ras [6];
		logic [31:0] decs [5];
		ras = '{32'h0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h8000_0000,
			32'hC000_0000, 32'h3FFF_FFFF};
		// poles, equator and beyond a quarter turn
		decs = '{32'h4000_0000, 32'hC000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
		foreach (decs[d])
			for (int k = 0; k < 4; k++)
				send_direction(ras[(d + k) % 6], decs[d]);
		send_direction(32'hFFFF_FFFF, 32'h4000_0001);
		send_direction(32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	task automatic test_random_directions(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_direction(phase_ra + $urandom_range(0, 64) - 32, pick_dec());
			else
				send_direction($urandom, pick_dec());
		end
	endtask

	task automatic test_reference_settings();
		logic [31:0] ref_ras [4];
		logic [31:0] ref_decs [4];
		ref_ras = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h1234_5678};
		// near the poles the radicand may go negative and clamp
		ref_decs = '{32'h4000_0000, 32'hC000_0000, 32'h2000_0000, 32'h0};
		foreach (ref_ras[k]) begin
			drain_pipeline();
			write_reference(rlmn_pkg::REG_REF_RA, ref_ras[k]);
			write_reference(rlmn_pkg::REG_REF_DEC, ref_decs[k]);
			test_random_directions(120);
		end
		for (int k = 0; k < 4; k++) begin
			drain_pipeline();
			write_reference(rlmn_pkg::REG_REF_RA, $urandom);
			write_reference(rlmn_pkg::REG_REF_DEC, pick_dec());
			test_random_directions(120);
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_random_directions(100);
		test_reference_settings();
		drain_pipeline();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hdl/rlmn_pkg.sv
hdl/rlmn_cordic.sv
hdl/rlmn_sqrt.sv
hdl/radec_to_lmn_direction_cosines.sv
verif/testbench.sv
